@@ hw/rtl/bba_pkg.sv @@
// bba_pkg: shared constants and types for the buddy block allocator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_SIZE = 2'd1;
	localparam logic [1:0] ST_NO_PAGE  = 2'd2;
	localparam logic [1:0] ST_BAD_FREE = 2'd3;
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;
	localparam int HDR_BYTES = 9;
	localparam int MIN_SIZE  = 7;

	typedef struct packed {
		logic       start;
		logic       used;
		logic [4:0] order;
	} map_entry_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [14:0] granted_address;
		logic [3:0]  granted_order;
		logic        page_released;
	} result_t;
endpackage
`default_nettype wire

@@ hw/rtl/bba_req_if.sv @@
// bba_req_if: request and result channel interfaces.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface bba_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [15:0] request_size;
	logic [14:0] block_address;
	modport source (output valid, command, request_size, block_address, input ready);
	modport sink (input valid, command, request_size, block_address, output ready);
endinterface

interface bba_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [14:0] granted_address;
	logic [3:0]  granted_order;
	logic        page_released;
	modport source (output valid, status, granted_address, granted_order, page_released,
		input ready);
	modport sink (input valid, status, granted_address, granted_order, page_released,
		output ready);
endinterface

interface bba_cfg_if;
	logic valid;
	logic ready;
	logic data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/bba_map_ram.sv @@
// bba_map_ram: block map memory, one entry per granule, registered read.
// Depends on bba_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bba_map_ram #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire  [AW-1:0]           waddr,
	input  bba_pkg::map_entry_t     wdata,
	input  wire  [AW-1:0]           raddr,
	output bba_pkg::map_entry_t     rdata
);
	bba_pkg::map_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ hw/rtl/buddy_block_allocator.sv @@
// buddy_block_allocator: top level, sequencer over the block map memory.
// Depends on bba_pkg, bba_req_if, bba_map_ram.
//
//  channel | dir | payload
//  req     | in  | command, request_size, block_address
//  rsp     | out | status, granted_address, granted_order, page_released
//  cfg     | in  | fit_mode
//
// Allocate scans the map of every page in use, one entry a cycle (first-fit
// mode stops at the first fitting block), then in S_SPLIT writes a free buddy head
// per split and then the used head, then posts the item in S_OUT.
// Free reads and checks the block (S_FRD, S_FCHK), then runs S_BRD, S_BCHK and
// S_SHIFT per merge level. A page release clears its granules one a cycle. After
// reset the whole map is cleared, one entry a cycle, before requests are taken.
// One request at a time; the result register holds while rsp is stalled.
`timescale 1ns / 1ps
`default_nettype none
module buddy_block_allocator #(
	parameter int NUM_PAGES  = 8,
	parameter int PAGE_ORDER = 12,
	parameter int MIN_ORDER  = 4
) (
	input wire clk,
	input wire arst_n,
	bba_req_if.sink   req,
	bba_rsp_if.source rsp,
	bba_cfg_if.sink   cfg
);
	localparam int GB    = PAGE_ORDER - MIN_ORDER;
	localparam int GRANS = 1 << GB;
	localparam int PW    = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam int CW    = $clog2(NUM_PAGES + 1);
	localparam int AW    = PW + GB;
	localparam int DEPTH = NUM_PAGES * GRANS;

	localparam logic [3:0] S_CLR    = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_SCAN   = 4'd2;
	localparam logic [3:0] S_SPLIT  = 4'd3;
	localparam logic [3:0] S_FRD    = 4'd4;
	localparam logic [3:0] S_FCHK   = 4'd5;
	localparam logic [3:0] S_BRD    = 4'd6;
	localparam logic [3:0] S_BCHK   = 4'd7;
	localparam logic [3:0] S_REL    = 4'd8;
	localparam logic [3:0] S_OUT    = 4'd9;
	localparam logic [3:0] S_SHIFT  = 4'd10;

	logic [3:0]     state_q;
	logic           fit_q;
	logic [NUM_PAGES-1:0] inuse_q;
	logic [PW-1:0]  seq_q [NUM_PAGES];
	logic [CW-1:0]  cnt_q;
	logic [AW-1:0]  clr_q;
	logic [4:0]     need_q, best_o_q, o_q;
	logic [AW-1:0]  best_a_q;
	logic           found_q;
	logic [CW-1:0]  k_q;
	logic [GB-1:0]  g_q;
	logic           rv_q;
	logic [AW-1:0]  ra_q;
	logic [PW-1:0]  f_q;
	logic [GB-1:0]  off_q;
	logic           rel_q;
	bba_pkg::result_t res_q;
	logic           ovalid_q;

	// merge bookkeeping: old head cleared in S_SHIFT, merged head written in S_BRD
	logic          mw_q;
	logic [AW-1:0] mwa_q;

	logic                we;
	logic [AW-1:0]       waddr, raddr;
	bba_pkg::map_entry_t wdata, rdata;

	bba_map_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// size to order
	logic [4:0] need_c;
	always_comb begin
		logic [16:0] t;
		need_c = '0;
		t = {1'b0, req.request_size} + 17'(bba_pkg::HDR_BYTES);
		if (req.request_size >= 16'(bba_pkg::MIN_SIZE) &&
				{1'b0, req.request_size} <= 17'((1 << PAGE_ORDER) - 8)) begin
			for (int k = PAGE_ORDER; k >= MIN_ORDER; k--)
				if (t <= 17'(1 << k)) need_c = 5'(k);
		end
	end

	// lowest free frame
	logic [PW-1:0] ff_c;
	logic          ff_ok;
	always_comb begin
		ff_c = '0;
		ff_ok = 1'b0;
		for (int i = NUM_PAGES - 1; i >= 0; i--)
			if (!inuse_q[i]) begin
				ff_c = PW'(i);
				ff_ok = 1'b1;
			end
	end

	logic [PW-1:0] fr_c;
	assign fr_c = PW'(req.block_address >> PAGE_ORDER);
	logic fr_bad;
	assign fr_bad = (req.block_address[MIN_ORDER-1:0] != '0) ||
		(32'(req.block_address >> PAGE_ORDER) >= NUM_PAGES) || !inuse_q[fr_c];

	logic [GB-1:0] bit_c;
	assign bit_c = GB'(1) << (o_q - 5'(MIN_ORDER));
	logic scan_end;
	assign scan_end = (g_q == GB'(GRANS - 1));
	logic [PW-1:0] cur_pg;
	assign cur_pg = seq_q[k_q[PW-1:0]];
	logic hit;
	assign hit = rv_q && rdata.start && !rdata.used && rdata.order >= need_q;

	assign req.ready = (state_q == S_IDLE) && !ovalid_q;
	assign cfg.ready = 1'b1;
	assign rsp.valid = ovalid_q;
	assign rsp.status = res_q.status;
	assign rsp.granted_address = res_q.granted_address;
	assign rsp.granted_order = res_q.granted_order;
	assign rsp.page_released = res_q.page_released;

	always_comb begin
		we = 1'b0;
		waddr = ra_q;
		wdata = '0;
		raddr = ra_q;
		unique case (state_q)
			S_CLR: begin
				we = 1'b1;
				waddr = clr_q;
			end
			S_SCAN: raddr = {cur_pg, g_q};
			S_SPLIT: begin
				we = 1'b1;
				if (o_q > need_q) begin
					waddr = best_a_q + AW'(GB'(1) << (o_q - 5'd1 - 5'(MIN_ORDER)));
					wdata = '{start: 1'b1, used: 1'b0, order: o_q - 5'd1};
				end else begin
					waddr = best_a_q;
					wdata = '{start: 1'b1, used: 1'b1, order: need_q};
				end
			end
			S_FRD: raddr = {f_q, off_q};
			S_FCHK: begin
				waddr = {f_q, off_q};
				we = rdata.start && rdata.used;
				wdata = '{start: 1'b1, used: 1'b0,
					order: (rdata.order > 5'(PAGE_ORDER) || rdata.order < 5'(MIN_ORDER)) ?
						5'(PAGE_ORDER) : rdata.order};
			end
			S_BRD: begin
				raddr = {f_q, off_q ^ bit_c};
				// merged head from the previous level
				we = mw_q;
				waddr = {f_q, off_q};
				wdata = '{start: 1'b1, used: 1'b0, order: o_q};
			end
			S_BCHK: begin
				we = rdata.start && !rdata.used && rdata.order == o_q;
				waddr = {f_q, off_q ^ bit_c};
				wdata = '0;
			end
			S_SHIFT: begin
				we = 1'b1;
				waddr = mwa_q;
				wdata = '0;
			end
			S_REL: begin
				we = 1'b1;
				waddr = {f_q, g_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			fit_q    <= 1'b0;
			inuse_q  <= '0;
			cnt_q    <= '0;
			clr_q    <= '0;
			ovalid_q <= 1'b0;
			rv_q     <= 1'b0;
			mw_q     <= 1'b0;
		end else begin
			if (cfg.valid) fit_q <= cfg.data;
			if (rsp.ready && ovalid_q) ovalid_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (req.valid && !ovalid_q) begin
					rel_q <= 1'b0;
					rv_q  <= 1'b0;
					if (req.command == bba_pkg::CMD_ALLOC) begin
						need_q   <= need_c;
						found_q  <= 1'b0;
						best_o_q <= 5'(PAGE_ORDER + 1);
						k_q <= '0;
						g_q <= '0;
						if (need_c == '0) begin
							res_q <= '{status: bba_pkg::ST_BAD_SIZE, granted_address: '0,
								granted_order: '0, page_released: 1'b0};
							state_q <= S_OUT;
						end else begin
							res_q <= '0;
							state_q <= S_SCAN;
						end
					end else begin
						f_q   <= fr_c;
						off_q <= req.block_address[PAGE_ORDER-1:MIN_ORDER];
						if (fr_bad) begin
							res_q <= '{status: bba_pkg::ST_BAD_FREE, granted_address: '0,
								granted_order: '0, page_released: 1'b0};
							state_q <= S_OUT;
						end else begin
							res_q <= '0;
							state_q <= S_FRD;
						end
					end
				end
				S_SCAN: begin
					logic stop;
					stop = 1'b0;
					if (hit) begin
						if (rdata.order < best_o_q) begin
							best_o_q <= rdata.order;
							best_a_q <= ra_q;
							found_q  <= 1'b1;
						end
						if (fit_q) stop = 1'b1;
					end
					if (k_q < cnt_q && !stop && !(found_q && fit_q)) begin
						rv_q <= 1'b1;
						ra_q <= {cur_pg, g_q};
						if (scan_end) begin
							g_q <= '0;
							k_q <= k_q + 1'b1;
						end else g_q <= g_q + 1'b1;
					end else begin
						rv_q <= 1'b0;
						if (!rv_q || stop || (found_q && fit_q)) begin
							// drained
							if (found_q || hit) begin
								o_q <= (hit && rdata.order < best_o_q) ? rdata.order : best_o_q;
								state_q <= S_SPLIT;
							end else if (!ff_ok || cnt_q >= CW'(NUM_PAGES)) begin
								res_q.status <= bba_pkg::ST_NO_PAGE;
								state_q <= S_OUT;
							end else begin
								inuse_q[ff_c] <= 1'b1;
								seq_q[cnt_q[PW-1:0]] <= ff_c;
								cnt_q <= cnt_q + 1'b1;
								best_a_q <= {ff_c, GB'(0)};
								o_q <= 5'(PAGE_ORDER);
								state_q <= S_SPLIT;
							end
						end
					end
				end
				S_SPLIT: begin
					if (o_q > need_q) o_q <= o_q - 5'd1;
					else begin
						res_q.granted_address <= 15'({best_a_q, MIN_ORDER'(0)});
						res_q.granted_order <= need_q[3:0];
						state_q <= S_OUT;
					end
				end
				S_FRD: state_q <= S_FCHK;
				S_FCHK: begin
					if (!(rdata.start && rdata.used)) begin
						res_q.status <= bba_pkg::ST_BAD_FREE;
						state_q <= S_OUT;
					end else begin
						o_q <= (rdata.order > 5'(PAGE_ORDER) || rdata.order < 5'(MIN_ORDER)) ?
							5'(PAGE_ORDER) : rdata.order;
						state_q <= S_BRD;
					end
				end
				S_BRD: begin
					if (mw_q) mw_q <= 1'b0;
					if (o_q >= 5'(PAGE_ORDER)) begin
						g_q <= '0;
						state_q <= S_REL;
					end else state_q <= S_BCHK;
				end
				S_BCHK: begin
					if (rdata.start && !rdata.used && rdata.order == o_q) begin
						mw_q  <= 1'b1;
						mwa_q <= {f_q, off_q};
						off_q <= off_q & ~bit_c;
						o_q   <= o_q + 5'd1;
						state_q <= S_SHIFT;
					end else state_q <= S_OUT;
				end
				S_SHIFT: state_q <= S_BRD;
				S_REL: begin
					g_q <= g_q + 1'b1;
					if (scan_end) begin
						inuse_q[f_q] <= 1'b0;
						k_q <= '0;
						rel_q <= 1'b1;
						res_q.page_released <= 1'b1;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (rel_q) begin
						// remove frame from sequence, compact
						for (int i = 0; i < NUM_PAGES; i++) begin
							logic past;
							past = 1'b0;
							for (int j = 0; j <= i; j++)
								if (CW'(j) < cnt_q && seq_q[j] == f_q) past = 1'b1;
							if (past && i + 1 < NUM_PAGES)
								seq_q[i] <= seq_q[(i + 1) % NUM_PAGES];
						end
						cnt_q <= cnt_q - 1'b1;
					end
					ovalid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_one_out: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && !rsp.ready |=> ovalid_q) else $error("result dropped");
	a_no_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !req.ready) else $error("ready while busy");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(NUM_PAGES)) else $error("page count overflow");
endmodule
`default_nettype wire

@@ tb/buddy_block_allocator_tb.sv @@
// buddy_block_allocator_tb: self-checking bench for the buddy block allocator.
// Depends on bba_pkg, bba_req_if/bba_rsp_if/bba_cfg_if and buddy_block_allocator.
`timescale 1ns / 1ps
`default_nettype none
module buddy_block_allocator_tb;

	localparam int PAGES = 8;
	localparam int PG_ORD = 12;
	localparam int MN_ORD = 4;
	localparam int GRN = 1 << (PG_ORD - MN_ORD);
	localparam int IDLE_LIMIT = 200000;
	localparam int N_RANDOM = 1100;

	// allocator mirror: granule map, frames, frame order, selection mode
	class alloc_scoreboard;
		bba_pkg::map_entry_t granule[PAGES * GRN];
		bit frame_busy[PAGES];
		int frame_seq[PAGES];
		int frame_cnt;
		bit first_fit;
		bba_pkg::result_t pending[$];
		int errors;
		int live_addr[$];

		function void clear();
			foreach (granule[i]) granule[i] = '0;
			foreach (frame_busy[i]) frame_busy[i] = 0;
			foreach (frame_seq[i]) frame_seq[i] = 0;
			frame_cnt = 0;
			first_fit = 0;
			errors = 0;
		endfunction

		function int size_order(int s);
			if (s < bba_pkg::MIN_SIZE || s > (1 << PG_ORD) - 8) return 0;
			for (int k = MN_ORD; k <= PG_ORD; k++)
				if (s + bba_pkg::HDR_BYTES <= (1 << k)) return k;
			return 0;
		endfunction

		function bba_pkg::result_t grant(int s);
			bba_pkg::result_t r;
			int need, bo, bg, f, o;
			bit hit;
			r = '0;
			need = size_order(s);
			bo = PG_ORD + 1;
			bg = 0;
			hit = 0;
			if (need == 0) begin
				r.status = bba_pkg::ST_BAD_SIZE;
				return r;
			end
			for (int k = 0; k < frame_cnt; k++) begin
				int base;
				base = frame_seq[k] * GRN;
				for (int g = 0; g < GRN; g++) begin
					bba_pkg::map_entry_t e;
					e = granule[base + g];
					if (e.start && !e.used && e.order >= need) begin
						if (e.order < bo) begin
							bo = e.order;
							bg = base + g;
							hit = 1;
						end
						if (first_fit) break;
					end
				end
				if (hit && first_fit) break;
			end
			if (!hit) begin
				for (f = 0; f < PAGES; f++)
					if (!frame_busy[f]) break;
				if (f >= PAGES || frame_cnt >= PAGES) begin
					r.status = bba_pkg::ST_NO_PAGE;
					return r;
				end
				frame_busy[f] = 1;
				frame_seq[frame_cnt++] = f;
				bg = f * GRN;
				bo = PG_ORD;
			end
			o = bo;
			while (o > need) begin
				o--;
				granule[bg + (1 << (o - MN_ORD))] = '{1'b1, 1'b0, 5'(o)};
			end
			granule[bg] = '{1'b1, 1'b1, 5'(need)};
			r.status = bba_pkg::ST_OK;
			r.granted_address = 15'(bg << MN_ORD);
			r.granted_order = 4'(need);
			live_addr.push_back(bg << MN_ORD);
			return r;
		endfunction

		function bba_pkg::result_t release_blk(int a);
			bba_pkg::result_t r;
			int f, base, off, o, bit_;
			bba_pkg::map_entry_t e, b;
			r = '0;
			f = a >> PG_ORD;
			if ((a & ((1 << MN_ORD) - 1)) != 0 || f >= PAGES || !frame_busy[f]) begin
				r.status = bba_pkg::ST_BAD_FREE;
				return r;
			end
			base = f * GRN;
			off = (a >> MN_ORD) & (GRN - 1);
			e = granule[base + off];
			if (!e.start || !e.used) begin
				r.status = bba_pkg::ST_BAD_FREE;
				return r;
			end
			foreach (live_addr[i])
				if (live_addr[i] == a) begin
					live_addr.delete(i);
					break;
				end
			o = e.order;
			if (o > PG_ORD || o < MN_ORD) o = PG_ORD;
			granule[base + off] = '{1'b1, 1'b0, 5'(o)};
			while (o < PG_ORD) begin
				bit_ = 1 << (o - MN_ORD);
				b = granule[base + ((off ^ bit_) & (GRN - 1))];
				if (!b.start || b.used || b.order != o) break;
				granule[base + ((off ^ bit_) & (GRN - 1))] = '0;
				granule[base + off] = '0;
				off &= ~bit_;
				o++;
				granule[base + off] = '{1'b1, 1'b0, 5'(o)};
			end
			r.status = bba_pkg::ST_OK;
			if (o >= PG_ORD) begin
				for (int g = 0; g < GRN; g++) granule[base + g] = '0;
				frame_busy[f] = 0;
				for (int k = 0; k < frame_cnt; k++)
					if (frame_seq[k] == f) begin
						for (; k + 1 < frame_cnt; k++) frame_seq[k] = frame_seq[k + 1];
						frame_cnt--;
						break;
					end
				r.page_released = 1;
			end
			return r;
		endfunction

		function void note_request(logic c, logic [15:0] s, logic [14:0] a);
			if (c == bba_pkg::CMD_ALLOC) pending.push_back(grant(int'(s)));
			else pending.push_back(release_blk(int'(a)));
		endfunction

		function void check_result(bba_pkg::result_t got);
			bba_pkg::result_t x;
			if (pending.size() == 0) begin
				$error("result with nothing expected: %p", got);
				errors++;
				return;
			end
			x = pending.pop_front();
			if (got.status !== x.status) begin
				$error("status expected %0d actual %0d", x.status, got.status);
				errors++;
			end
			if (got.granted_address !== x.granted_address) begin
				$error("granted_address expected %0h actual %0h",
					x.granted_address, got.granted_address);
				errors++;
			end
			if (got.granted_order !== x.granted_order) begin
				$error("granted_order expected %0d actual %0d",
					x.granted_order, got.granted_order);
				errors++;
			end
			if (got.page_released !== x.page_released) begin
				$error("page_released expected %0d actual %0d",
					x.page_released, got.page_released);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	always #5 clk = ~clk;

	bba_req_if req();
	bba_rsp_if rsp();
	bba_cfg_if cfg();

	buddy_block_allocator u_top (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg)
	);

	alloc_scoreboard sb = new();
	int idle_cycles = 0;
	int burst_left = 0;

	initial begin
		req.valid = 0;
		req.command = bba_pkg::CMD_ALLOC;
		req.request_size = '0;
		req.block_address = '0;
		cfg.valid = 0;
		cfg.data = 0;
		sb.clear();
	end

	// monitor: sample at rising edge
	always @(posedge clk) begin
		if (req.valid && req.ready || rsp.valid && rsp.ready || cfg.valid && cfg.ready)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (arst_n && rsp.valid && rsp.ready)
			sb.check_result('{rsp.status, rsp.granted_address, rsp.granted_order,
				rsp.page_released});
	end

	// receiver stall pattern: ready drawn at random on every falling edge, mostly high
	always @(negedge clk)
		rsp.ready <= ($urandom_range(0, 3) != 0) || (($urandom_range(0, 63)) < 8);

	always @(posedge clk)
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("buddy_block_allocator_tb NOT OK");
			$finish;
		end

	task automatic send(logic c, logic [15:0] s, logic [14:0] a);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
			repeat (gap) @(negedge clk);
		end
		burst_left--;
		req.valid = 1;
		req.command = c;
		req.request_size = s;
		req.block_address = a;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		sb.note_request(c, s, a);
		@(negedge clk);
		req.valid = 0;
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (12000) @(negedge clk);
	endtask

	task automatic set_fit(bit m);
		drain();
		cfg.valid = 1;
		cfg.data = m;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		sb.first_fit = m;
		@(negedge clk);
		cfg.valid = 0;
	endtask

	task automatic alloc(int s);
		send(bba_pkg::CMD_ALLOC, 16'(s), 15'($urandom));
	endtask

	task automatic free_any();
		int i;
		if (sb.live_addr.size() == 0) begin
			alloc($urandom_range(7, 200));
			return;
		end
		i = $urandom_range(0, sb.live_addr.size() - 1);
		send(bba_pkg::CMD_FREE, 16'($urandom), 15'(sb.live_addr[i]));
	endtask

	task automatic random_item();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45) begin
			if ($urandom_range(0, 9) < 8) alloc($urandom_range(7, 600));
			else alloc($urandom_range(7, 4088));
		end else if (p < 88) free_any();
		else if (p < 93) alloc($urandom);
		else if (p < 97) send(bba_pkg::CMD_FREE, 16'($urandom), 15'($urandom));
		else if (sb.live_addr.size() != 0)
			// off the start of a live block: misaligned, or a later granule
			send(bba_pkg::CMD_FREE, 16'($urandom),
				15'(sb.live_addr[0] + $urandom_range(1, 31)));
		else alloc(7);
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1;
		set_fit(1);
		set_fit(0);
		// directed: size extremes, bad frees, page exhaustion, release
		alloc(0);
		alloc(6);
		alloc(4089);
		alloc(16'hFFFF);
		alloc(7);
		alloc(8);
		alloc(23);
		alloc(4087);
		alloc(4088);
		send(bba_pkg::CMD_FREE, 16'hFFFF, 15'h7FFF);
		send(bba_pkg::CMD_FREE, 16'd0, 15'h0008);
		send(bba_pkg::CMD_FREE, 16'd0, 15'h0010);
		send(bba_pkg::CMD_FREE, 16'd0, 15'h6000);
		for (int i = 0; i < 7; i++) alloc(4087);
		alloc(100);
		while (sb.live_addr.size() != 0)
			send(bba_pkg::CMD_FREE, 16'd0, 15'(sb.live_addr[0]));
		send(bba_pkg::CMD_FREE, 16'd0, 15'h0000);
		set_fit(1);
		alloc(7); alloc(500); alloc(7); free_any(); alloc(20);
		for (int ph = 0; ph < 4; ph++) begin
			set_fit(ph[0]);
			for (int i = 0; i < N_RANDOM / 4; i++) begin
				random_item();
				if (ph == 2 && i == 100) drain();
			end
		end
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("buddy_block_allocator_tb OK");
		else
			$display("buddy_block_allocator_tb NOT OK");
		$finish;
	end
endmodule
`default_nettype wire

@@ sim.f @@
hw/rtl/bba_pkg.sv
hw/rtl/bba_req_if.sv
hw/rtl/bba_map_ram.sv
hw/rtl/buddy_block_allocator.sv
tb/buddy_block_allocator_tb.sv
